[design/brs_pkg.sv]
// ----------------------------------------------------------------------------
// brs_pkg - shared definitions for the block-decomposed range sum
// Widths, register selects, command codes, sequencer states and the
// divider result bundle.
// ----------------------------------------------------------------------------
package brs_pkg;

	localparam int MAX_ELEMENTS = 1024;
	localparam int MAX_BLOCKS   = 32;

	localparam int DATA_W  = 32;
	localparam int IDX_W   = $clog2(MAX_ELEMENTS);
	localparam int BLK_W   = $clog2(MAX_BLOCKS);
	localparam int COUNT_W = 11;
	localparam int BS_W    = 6;
	localparam int LEN_W   = BS_W + 1;
	localparam int BCNT_W  = BLK_W + 1;
	localparam int STEP_W  = $clog2(IDX_W);
	localparam int ADDR_W  = 3;

	localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);
	localparam logic [BS_W-1:0]    BSIZE_RESET = BS_W'(32);
	localparam logic [COUNT_W-1:0] COUNT_CAP   = COUNT_W'(MAX_ELEMENTS);

	// register select: bit 2 of the byte address
	localparam int   REG_SEL_BIT = 2;
	localparam logic REG_COUNT   = 1'b0;
	localparam logic REG_BSIZE   = 1'b1;

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_SUM    = 2'd1,
		CMD_UPDATE = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_RMW_RD,
		ST_RMW_WR,
		ST_PLAN,
		ST_E1,
		ST_E2,
		ST_BLK,
		ST_DRAIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic             done;
		logic [IDX_W-1:0] quo;
		logic [BS_W-1:0]  rem;
	} div_res_t;

endpackage

[design/brs_div.sv]
// ----------------------------------------------------------------------------
// brs_div - index by block size divider
// Restoring radix-2 divider, one quotient bit per cycle. Quotient and
// remainder hold after done until the next start.
// ----------------------------------------------------------------------------
module brs_div import brs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [IDX_W-1:0] dividend,
	input  logic [BS_W-1:0]  divisor,
	output div_res_t         res
);

	logic [IDX_W-1:0]  quo_q;
	logic [BS_W-1:0]   rem_q;
	logic [BS_W-1:0]   dvs_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [BS_W:0]     trial;
	logic              fits;

	// shift in the next dividend bit and try the subtract
	assign trial = {rem_q, quo_q[IDX_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(IDX_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[IDX_W-2:0], fits};
			rem_q <= fits ? BS_W'(trial - {1'b0, dvs_q}) : trial[BS_W-1:0];
		end
	end

	assign res.done = done_q;
	assign res.quo  = quo_q;
	assign res.rem  = rem_q;

endmodule

[design/block_decomposed_range_sum.sv]
// ----------------------------------------------------------------------------
// block_decomposed_range_sum - range sum over blocked array, point update
// Load/update: divider, element and block-sum read, write back, then idle.
// Sum: divider, plan, loose head, loose tail and block-sum reads, drain, then
// result; a new beat is taken only once the sequencer is back in idle.
// Bad range: straight to the result state, no divider run.
// Reset: block-sum valid bits clear at once, count 1024, block size 32.
// ----------------------------------------------------------------------------
module block_decomposed_range_sum import brs_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  logic                      cmd_valid,
	output logic                      cmd_stall,
	input  logic [1:0]                command,
	input  logic [IDX_W-1:0]          first_index,
	input  logic [IDX_W-1:0]          last_index,
	input  logic signed [DATA_W-1:0]  value,
	output logic                      res_valid,
	input  logic                      res_stall,
	output logic signed [DATA_W-1:0]  range_sum,
	output logic                      range_error
);

	// configuration
	logic [COUNT_W-1:0] count_q;
	logic [BS_W-1:0]    bsize_q;
	logic [COUNT_W-1:0] n_eff;
	logic [BS_W-1:0]    bs_eff;
	logic               cfg_wr;

	// current item
	state_t             state_q, state_d;
	cmd_t               cmd_q;
	logic [IDX_W-1:0]   x_q, y_q;
	logic [DATA_W-1:0]  value_q;
	logic [COUNT_W-1:0] n_q;
	logic [BS_W-1:0]    bs_q;
	logic               err_q;
	logic [DATA_W-1:0]  acc_q;
	logic               cmd_acc;
	logic               idx_ok;
	logic               rng_err;

	// dividers
	logic     div_start;
	div_res_t xd, yd;

	// plan
	logic [BS_W-1:0]    bsm1;
	logic [IDX_W-1:0]   span;
	logic               direct;
	logic               x_part;
	logic               y_whole;
	logic [COUNT_W-1:0] blk_first;
	logic [IDX_W-1:0]   blk_last_raw;
	logic [BLK_W-1:0]   blk_last;
	logic               blk_none;
	logic [LEN_W-1:0]   e1_cnt_d, e2_cnt_d;
	logic [IDX_W-1:0]   e2_ptr_d;
	logic [BCNT_W-1:0]  bk_cnt_d;

	// sequencer counters
	logic [IDX_W-1:0]  e1_ptr_q, e2_ptr_q;
	logic [LEN_W-1:0]  e1_cnt_q, e2_cnt_q;
	logic [BLK_W-1:0]  bk_ptr_q;
	logic [BCNT_W-1:0] bk_cnt_q;

	// memories
	logic [DATA_W-1:0] elem_mem [MAX_ELEMENTS];
	logic [DATA_W-1:0] blk_mem [MAX_BLOCKS];
	logic [MAX_BLOCKS-1:0] blk_vld_q;
	logic              elem_rd_en, elem_wr_en, blk_rd_en, blk_wr_en;
	logic [IDX_W-1:0]  elem_rd_addr;
	logic [BLK_W-1:0]  blk_rd_addr;
	logic              blk_hit;
	logic [DATA_W-1:0] elem_rdata_s1, blk_rdata_s1;
	logic              blk_bit_s1;
	logic [DATA_W-1:0] blk_word_s1;
	logic [DATA_W-1:0] delta;
	logic [DATA_W-1:0] blk_wr_data;
	logic              sum_e, sum_b;
	logic              sum_e_s1, sum_b_s1;

	// output register
	logic              res_valid_q;
	logic [DATA_W-1:0] range_sum_q;
	logic              range_error_q;
	logic              out_load;

	// ------------------------------------------------------------------
	// configuration port
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
			bsize_q <= BSIZE_RESET;
		end else if (cfg_wr) begin
			if (paddr[REG_SEL_BIT] == REG_COUNT) begin
				count_q <= pwdata[COUNT_W-1:0];
			end else begin
				bsize_q <= pwdata[BS_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[REG_SEL_BIT] == REG_COUNT) begin
			prdata = {{(32-COUNT_W){1'b0}}, count_q};
		end else begin
			prdata = {{(32-BS_W){1'b0}}, bsize_q};
		end
	end

	// clamp count to the store, block size zero acts as one
	assign n_eff  = (count_q > COUNT_CAP) ? COUNT_CAP : count_q;
	assign bs_eff = (bsize_q == '0) ? BS_W'(1) : bsize_q;

	// ------------------------------------------------------------------
	// input beat
	// ------------------------------------------------------------------
	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign idx_ok    = {1'b0, first_index} < n_eff;
	assign rng_err   = (first_index > last_index) || ({1'b0, last_index} >= n_eff);

	// latch the item
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			cmd_q   <= cmd_t'(command);
			x_q     <= first_index;
			y_q     <= last_index;
			value_q <= value;
			n_q     <= n_eff;
			bs_q    <= bs_eff;
			err_q   <= rng_err;
		end
	end

	// ------------------------------------------------------------------
	// dividers: index / block size for both range ends
	// ------------------------------------------------------------------
	brs_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (first_index),
		.divisor  (bs_eff),
		.res      (xd)
	);

	brs_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (last_index),
		.divisor  (bs_eff),
		.res      (yd)
	);

	// ------------------------------------------------------------------
	// query plan: loose head, loose tail, run of block sums
	// ------------------------------------------------------------------
	always_comb begin
		bsm1         = bs_q - BS_W'(1);
		span         = y_q - x_q;
		direct       = span < IDX_W'(bsm1);
		x_part       = (xd.rem != '0);
		y_whole      = (yd.rem == bsm1) || ({1'b0, y_q} == (n_q - COUNT_W'(1)));
		blk_first    = COUNT_W'(xd.quo) + COUNT_W'(x_part);
		blk_last_raw = y_whole ? yd.quo : (yd.quo - IDX_W'(1));
		blk_none     = direct || (!y_whole && (yd.quo == '0));
		blk_last     = (blk_last_raw >= IDX_W'(MAX_BLOCKS)) ? BLK_W'(MAX_BLOCKS - 1)
		                                                    : blk_last_raw[BLK_W-1:0];
		if (blk_none || (blk_first > COUNT_W'(blk_last))) begin
			bk_cnt_d = '0;
		end else begin
			bk_cnt_d = BCNT_W'(blk_last) - BCNT_W'(blk_first[BLK_W-1:0]) + BCNT_W'(1);
		end
		if (direct) begin
			e1_cnt_d = LEN_W'(span) + LEN_W'(1);
		end else if (x_part) begin
			e1_cnt_d = LEN_W'(bs_q) - LEN_W'(xd.rem);
		end else begin
			e1_cnt_d = '0;
		end
		e2_ptr_d = y_q - IDX_W'(yd.rem);
		e2_cnt_d = (direct || y_whole) ? '0 : (LEN_W'(yd.rem) + LEN_W'(1));
	end

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign blk_hit = (xd.quo < IDX_W'(MAX_BLOCKS));

	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		elem_rd_en   = 1'b0;
		elem_rd_addr = x_q;
		elem_wr_en   = 1'b0;
		blk_rd_en    = 1'b0;
		blk_rd_addr  = xd.quo[BLK_W-1:0];
		blk_wr_en    = 1'b0;
		sum_e        = 1'b0;
		sum_b        = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd_t'(command))
						CMD_LOAD, CMD_UPDATE: begin
							if (idx_ok) begin
								div_start = 1'b1;
								state_d   = ST_DIV;
							end
						end
						CMD_SUM: begin
							if (rng_err) begin
								state_d = ST_OUT;
							end else begin
								div_start = 1'b1;
								state_d   = ST_DIV;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_DIV: begin
				if (xd.done && yd.done) begin
					state_d = (cmd_q == CMD_SUM) ? ST_PLAN : ST_RMW_RD;
				end
			end
			ST_RMW_RD: begin
				elem_rd_en = 1'b1;
				blk_rd_en  = blk_hit;
				state_d    = ST_RMW_WR;
			end
			ST_RMW_WR: begin
				elem_wr_en = 1'b1;
				blk_wr_en  = blk_hit;
				state_d    = ST_IDLE;
			end
			ST_PLAN: state_d = ST_E1;
			ST_E1: begin
				elem_rd_addr = e1_ptr_q;
				if (e1_cnt_q != '0) begin
					elem_rd_en = 1'b1;
					sum_e      = 1'b1;
				end else begin
					state_d = ST_E2;
				end
			end
			ST_E2: begin
				elem_rd_addr = e2_ptr_q;
				if (e2_cnt_q != '0) begin
					elem_rd_en = 1'b1;
					sum_e      = 1'b1;
				end else begin
					state_d = ST_BLK;
				end
			end
			ST_BLK: begin
				blk_rd_addr = bk_ptr_q;
				if (bk_cnt_q != '0) begin
					blk_rd_en = 1'b1;
					sum_b     = 1'b1;
				end else begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_OUT;
			ST_OUT: begin
				if (!res_valid_q || !res_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// advance walk pointers and counts
	always_ff @(posedge clk) begin
		case (state_q)
			ST_PLAN: begin
				e1_ptr_q <= x_q;
				e1_cnt_q <= e1_cnt_d;
				e2_ptr_q <= e2_ptr_d;
				e2_cnt_q <= e2_cnt_d;
				bk_ptr_q <= blk_first[BLK_W-1:0];
				bk_cnt_q <= bk_cnt_d;
			end
			ST_E1: begin
				if (sum_e) begin
					e1_ptr_q <= e1_ptr_q + IDX_W'(1);
					e1_cnt_q <= e1_cnt_q - LEN_W'(1);
				end
			end
			ST_E2: begin
				if (sum_e) begin
					e2_ptr_q <= e2_ptr_q + IDX_W'(1);
					e2_cnt_q <= e2_cnt_q - LEN_W'(1);
				end
			end
			ST_BLK: begin
				if (sum_b) begin
					bk_ptr_q <= bk_ptr_q + BLK_W'(1);
					bk_cnt_q <= bk_cnt_q - BCNT_W'(1);
				end
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// element store and block-sum store
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (elem_wr_en) begin
			elem_mem[x_q] <= value_q;
		end
		if (elem_rd_en) begin
			elem_rdata_s1 <= elem_mem[elem_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (blk_wr_en) begin
			blk_mem[xd.quo[BLK_W-1:0]] <= blk_wr_data;
		end
		if (blk_rd_en) begin
			blk_rdata_s1 <= blk_mem[blk_rd_addr];
			blk_bit_s1   <= blk_vld_q[blk_rd_addr];
		end
	end

	// mark written block sums; an unmarked entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_vld_q <= '0;
		end else if (blk_wr_en) begin
			blk_vld_q[xd.quo[BLK_W-1:0]] <= 1'b1;
		end
	end

	assign blk_word_s1 = blk_bit_s1 ? blk_rdata_s1 : '0;
	assign delta       = (cmd_q == CMD_LOAD) ? value_q : (value_q - elem_rdata_s1);
	assign blk_wr_data = blk_word_s1 + delta;

	// ------------------------------------------------------------------
	// accumulate read data in the cycle after issue
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_e_s1 <= 1'b0;
			sum_b_s1 <= 1'b0;
		end else begin
			sum_e_s1 <= sum_e;
			sum_b_s1 <= sum_b;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			acc_q <= '0;
		end else if (sum_e_s1) begin
			acc_q <= acc_q + elem_rdata_s1;
		end else if (sum_b_s1) begin
			acc_q <= acc_q + blk_word_s1;
		end
	end

	// ------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			range_sum_q   <= acc_q;
			range_error_q <= err_q;
		end
	end

	assign res_valid   = res_valid_q;
	assign range_sum   = range_sum_q;
	assign range_error = range_error_q;

endmodule
